/* src/bmg_pkg.sv */
// Shared types, command codes and constants of the Box-Muller noise and histogram unit.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package bmg_pkg;

	localparam logic [1:0] CMD_GEN   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam int LOG_STEPS    = 30;
	localparam int SQRT_STEPS   = 32;
	localparam int TAYLOR_TERMS = 5;

	localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
	localparam logic [31:0] TWO_LN2_Q28 = 32'd372130559;
	localparam logic [31:0] PI_Q30      = 32'd3373259426;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] uniform_a;
		logic [15:0] uniform_b;
		logic [3:0]  bin_select;
	} req_t;

	typedef struct packed {
		logic signed [15:0] noise_sample;
		logic [3:0]         bin_hit;
		logic [31:0]        bin_count;
	} rsp_t;

	typedef enum logic [4:0] {
		DP_NOP, DP_LOAD, DP_SQ, DP_LOGSTEP, DP_TH, DP_TL, DP_RAD, DP_SQRT,
		DP_ANG, DP_X, DP_Y, DP_T1, DP_T2, DP_T3, DP_S1, DP_S2, DP_MAG,
		DP_RND, DP_OUT
	} dp_op_t;

	typedef enum logic [1:0] {
		H_NONE, H_READ, H_INC, H_CLEAR
	} hist_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [4:0] idx;
		hist_op_t   hop;
	} cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       use_cos;
		logic       hit_ok;
	} status_t;

	// Divisors of the nested Taylor forms, innermost first.
	function automatic logic [6:0] taylor_div(input logic use_cos, input logic [2:0] j);
		logic [6:0] d;
		d = 7'd2;
		case (j)
			3'd0: d = use_cos ? 7'd90 : 7'd110;
			3'd1: d = use_cos ? 7'd56 : 7'd72;
			3'd2: d = use_cos ? 7'd30 : 7'd42;
			3'd3: d = use_cos ? 7'd12 : 7'd20;
			3'd4: d = use_cos ? 7'd2 : 7'd6;
			default: d = 7'd2;
		endcase
		return d;
	endfunction

	// floor(2^31 / divisor), used to estimate the quotient before one correction.
	function automatic logic [31:0] taylor_recip(input logic use_cos, input logic [2:0] j);
		logic [31:0] m;
		m = 32'd1073741824;
		case (j)
			3'd0: m = use_cos ? 32'd23860929 : 32'd19522578;
			3'd1: m = use_cos ? 32'd38347922 : 32'd29826161;
			3'd2: m = use_cos ? 32'd71582788 : 32'd51130563;
			3'd3: m = use_cos ? 32'd178956970 : 32'd107374182;
			3'd4: m = use_cos ? 32'd1073741824 : 32'd357913941;
			default: m = 32'd1073741824;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

/* src/bmg_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on bmg_pkg for the payload types.
`default_nettype none

interface bmg_req_if;
	logic          valid;
	logic          ready;
	bmg_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bmg_rsp_if;
	logic          valid;
	logic          ready;
	bmg_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/bmg_hist.sv */
// Histogram counter store: one write or one registered read per cycle, valid bits for clearing.
// Depends on bmg_pkg for the operation codes.
`default_nettype none

module bmg_hist #(
	parameter int NUM_BINS    = 10,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire bmg_pkg::hist_op_t           hop,
	input  wire logic [$clog2(NUM_BINS)-1:0] addr,
	output logic [COUNT_WIDTH-1:0]           count
);
	localparam int AW = $clog2(NUM_BINS);

	logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
	logic [COUNT_WIDTH-1:0] rd_q;
	logic                   rvalid_q;
	logic [AW-1:0]          addr_q;
	logic [NUM_BINS-1:0]    valid_q;
	logic [COUNT_WIDTH-1:0] next_count;

	assign count      = rvalid_q ? rd_q : '0;
	assign next_count = (&count) ? count : count + 1'b1;

	always_ff @(posedge clk) begin
		if (hop == bmg_pkg::H_READ) begin
			rd_q   <= mem[addr];
			addr_q <= addr;
		end
		if (hop == bmg_pkg::H_INC) begin
			mem[addr_q] <= next_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			case (hop)
				bmg_pkg::H_READ:  rvalid_q <= valid_q[addr];
				bmg_pkg::H_INC:   valid_q[addr_q] <= 1'b1;
				bmg_pkg::H_CLEAR: valid_q <= '0;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* src/bmg_datapath.sv */
// Arithmetic datapath: shared 32x32 multiplier, log2 squaring loop, bit-serial square root,
// Taylor sine/cosine and result forming. Depends on bmg_pkg.
`default_nettype none

module bmg_datapath #(
	parameter int NUM_BINS    = 10,
	parameter int COUNT_WIDTH = 32,
	parameter int FRAC_BITS   = 12
) (
	input  wire logic                        clk,
	input  wire bmg_pkg::cmd_t               cmd,
	input  wire bmg_pkg::req_t               req,
	input  wire logic [COUNT_WIDTH-1:0]      count,
	output bmg_pkg::status_t                 status,
	output logic [$clog2(NUM_BINS)-1:0]      hist_addr,
	output bmg_pkg::rsp_t                    rsp
);
	localparam int AW    = $clog2(NUM_BINS);
	localparam int Shift = 58 - FRAC_BITS;

	function automatic logic [3:0] top_bit(input logic [15:0] u);
		logic [3:0] p;
		p = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (u[i]) p = 4'(i);
		end
		return p;
	endfunction

	logic [1:0]         cmd_q;
	logic [3:0]         sel_q;
	logic [31:0]        m_q;
	logic [4:0]         pexp_q;
	logic [29:0]        frac_q;
	logic [14:0]        rr_q;
	logic               use_cos_q;
	logic               neg_q;
	logic [63:0]        prod_q;
	logic [63:0]        acc_q;
	logic [63:0]        sqv_q;
	logic [63:0]        res_q;
	logic [31:0]        x_q;
	logic [31:0]        y_q;
	logic [31:0]        h_q;
	logic [31:0]        v_q;
	logic signed [15:0] s_q;
	bmg_pkg::rsp_t      rsp_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [15:0] u;
	logic [3:0]  p;
	logic [13:0] r;
	logic        lo_half;
	logic [34:0] t;
	logic [65:0] rsum;
	logic [33:0] m2;
	logic [63:0] bitv, trial;
	logic [31:0] q0, q;
	logic [39:0] rem;
	logic [6:0]  dv;
	logic [63:0] rnd;
	logic [15:0] mag;
	logic signed [23:0] ks;
	logic        hit_ok;
	logic        sel_ok;
	logic [63:0] cnt64;

	assign u     = (req.uniform_a == 16'd0) ? 16'd1 : req.uniform_a;
	assign p     = top_bit(u);
	assign r     = req.uniform_b[13:0];
	assign lo_half = (r <= 14'd8192);
	assign t     = {pexp_q, 30'b0} - 35'(frac_q);
	assign rsum  = (66'(acc_q) << 17) + 66'(prod_q);
	assign m2    = prod_q[63:30];
	assign bitv  = 64'd1 << (6'd62 - {cmd.idx, 1'b0});
	assign trial = res_q + bitv;
	assign dv    = bmg_pkg::taylor_div(use_cos_q, cmd.idx[2:0]);
	assign q0    = prod_q[62:31];
	assign rem   = 40'(v_q) - 40'(q0) * 40'(dv);
	assign q     = (rem >= 40'(dv)) ? q0 + 32'd1 : q0;
	assign rnd   = (prod_q + (64'd1 << (Shift - 1))) >> Shift;
	assign ks    = $signed(($signed(24'(s_q)) - 24'sd1) >>> FRAC_BITS)
		+ $signed(24'(NUM_BINS / 2));
	assign hit_ok = (ks >= 24'sd0) && (ks < $signed(24'(NUM_BINS)));
	assign sel_ok = (32'(sel_q) < 32'(NUM_BINS));
	assign cnt64  = 64'(count);

	always_comb begin
		if (neg_q) begin
			mag = (rnd > 64'd32768) ? 16'h8000 : 16'(rnd);
		end else begin
			mag = (rnd > 64'd32767) ? 16'h7FFF : 16'(rnd);
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			bmg_pkg::DP_SQ: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			bmg_pkg::DP_TH: begin
				mul_a = 32'(t[34:17]);
				mul_b = bmg_pkg::TWO_LN2_Q28;
			end
			bmg_pkg::DP_TL: begin
				mul_a = 32'(t[16:0]);
				mul_b = bmg_pkg::TWO_LN2_Q28;
			end
			bmg_pkg::DP_ANG: begin
				mul_a = 32'(rr_q);
				mul_b = bmg_pkg::PI_Q30;
			end
			bmg_pkg::DP_X: begin
				mul_a = prod_q[46:15];
				mul_b = prod_q[46:15];
			end
			bmg_pkg::DP_T1: begin
				mul_a = y_q;
				mul_b = h_q;
			end
			bmg_pkg::DP_T2: begin
				mul_a = prod_q[61:30];
				mul_b = bmg_pkg::taylor_recip(use_cos_q, cmd.idx[2:0]);
			end
			bmg_pkg::DP_S1: begin
				mul_a = x_q;
				mul_b = h_q;
			end
			bmg_pkg::DP_MAG: begin
				mul_a = res_q[31:0];
				mul_b = h_q;
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		case (cmd.op)
			bmg_pkg::DP_LOAD: begin
				cmd_q     <= req.command;
				sel_q     <= req.bin_select;
				m_q       <= 32'(u) << (5'd30 - 5'(p));
				pexp_q    <= 5'd16 - 5'(p);
				frac_q    <= '0;
				rr_q      <= lo_half ? 15'(r) : 15'd16384 - 15'(r);
				use_cos_q <= lo_half ^ req.uniform_b[14];
				neg_q     <= req.uniform_b[15] ^ req.uniform_b[14];
			end
			bmg_pkg::DP_SQ, bmg_pkg::DP_TH, bmg_pkg::DP_ANG, bmg_pkg::DP_T1,
			bmg_pkg::DP_S1, bmg_pkg::DP_MAG: begin
				prod_q <= mul_p;
			end
			bmg_pkg::DP_LOGSTEP: begin
				// A square of two or more means the next log2 bit is one.
				if (m2 >= 34'h0_8000_0000) begin
					m_q <= 32'(m2 >> 1);
					frac_q[5'd29 - cmd.idx] <= 1'b1;
				end else begin
					m_q <= 32'(m2);
				end
			end
			bmg_pkg::DP_TL: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			bmg_pkg::DP_RAD: begin
				sqv_q <= 64'(rsum >> 30) << 28;
				res_q <= '0;
			end
			bmg_pkg::DP_SQRT: begin
				if (sqv_q >= trial) begin
					sqv_q <= sqv_q - trial;
					res_q <= (res_q >> 1) + bitv;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			bmg_pkg::DP_X: begin
				x_q    <= prod_q[46:15];
				prod_q <= mul_p;
			end
			bmg_pkg::DP_Y: begin
				y_q <= prod_q[61:30];
				h_q <= bmg_pkg::Q30_ONE;
			end
			bmg_pkg::DP_T2: begin
				v_q    <= prod_q[61:30];
				prod_q <= mul_p;
			end
			bmg_pkg::DP_T3: h_q <= bmg_pkg::Q30_ONE - q;
			bmg_pkg::DP_S2: h_q <= prod_q[61:30];
			bmg_pkg::DP_RND: s_q <= neg_q ? -$signed(mag) : $signed(mag);
			bmg_pkg::DP_OUT: begin
				rsp_q.noise_sample <= (cmd_q == bmg_pkg::CMD_GEN) ? s_q : 16'sd0;
				rsp_q.bin_hit      <= ((cmd_q == bmg_pkg::CMD_GEN) && hit_ok)
					? 4'(ks) : 4'(NUM_BINS);
				rsp_q.bin_count    <= ((cmd_q == bmg_pkg::CMD_READ) && sel_ok)
					? cnt64[31:0] : 32'd0;
			end
			default: ;
		endcase
	end

	assign hist_addr      = (cmd_q == bmg_pkg::CMD_READ) ? AW'(sel_q) : AW'(ks);
	assign status.command = cmd_q;
	assign status.use_cos = use_cos_q;
	assign status.hit_ok  = hit_ok;
	assign rsp            = rsp_q;

endmodule

`default_nettype wire

/* src/bmg_ctrl.sv */
// Sequencer of the noise unit: steps the datapath through log, root, angle and Taylor
// phases, issues the histogram operations and owns the handshakes. Depends on bmg_pkg.
`default_nettype none

module bmg_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	input  wire bmg_pkg::status_t status,
	output bmg_pkg::cmd_t         cmd
);
	typedef enum logic [21:0] {
		S_IDLE  = 22'h000001,
		S_LOAD  = 22'h000002,
		S_SQ    = 22'h000004,
		S_LSTEP = 22'h000008,
		S_TH    = 22'h000010,
		S_TL    = 22'h000020,
		S_RAD   = 22'h000040,
		S_SQRT  = 22'h000080,
		S_ANG   = 22'h000100,
		S_X     = 22'h000200,
		S_Y     = 22'h000400,
		S_T1    = 22'h000800,
		S_T2    = 22'h001000,
		S_T3    = 22'h002000,
		S_S1    = 22'h004000,
		S_S2    = 22'h008000,
		S_MAG   = 22'h010000,
		S_RND   = 22'h020000,
		S_HREAD = 22'h040000,
		S_HINC  = 22'h080000,
		S_CLEAR = 22'h100000,
		S_DONE  = 22'h200000
	} state_t;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       ovalid_q;
	logic       load_out;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = ovalid_q;
	assign load_out  = (state_q == S_DONE) && (!ovalid_q || rsp_ready);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd.op  = bmg_pkg::DP_NOP;
		cmd.idx = cnt_q;
		cmd.hop = bmg_pkg::H_NONE;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = bmg_pkg::DP_LOAD;
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cnt_d = '0;
				case (status.command)
					bmg_pkg::CMD_GEN:   state_d = S_SQ;
					bmg_pkg::CMD_READ:  state_d = S_HREAD;
					bmg_pkg::CMD_CLEAR: state_d = S_CLEAR;
					default:            state_d = S_DONE;
				endcase
			end
			S_SQ: begin
				cmd.op  = bmg_pkg::DP_SQ;
				state_d = S_LSTEP;
			end
			S_LSTEP: begin
				cmd.op = bmg_pkg::DP_LOGSTEP;
				if (cnt_q == 5'(bmg_pkg::LOG_STEPS - 1)) begin
					state_d = S_TH;
				end else begin
					cnt_d   = cnt_q + 5'd1;
					state_d = S_SQ;
				end
			end
			S_TH: begin
				cmd.op  = bmg_pkg::DP_TH;
				state_d = S_TL;
			end
			S_TL: begin
				cmd.op  = bmg_pkg::DP_TL;
				state_d = S_RAD;
			end
			S_RAD: begin
				cmd.op  = bmg_pkg::DP_RAD;
				cnt_d   = '0;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = bmg_pkg::DP_SQRT;
				if (cnt_q == 5'(bmg_pkg::SQRT_STEPS - 1)) begin
					state_d = S_ANG;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_ANG: begin
				cmd.op  = bmg_pkg::DP_ANG;
				state_d = S_X;
			end
			S_X: begin
				cmd.op  = bmg_pkg::DP_X;
				state_d = S_Y;
			end
			S_Y: begin
				cmd.op  = bmg_pkg::DP_Y;
				cnt_d   = '0;
				state_d = S_T1;
			end
			S_T1: begin
				cmd.op  = bmg_pkg::DP_T1;
				state_d = S_T2;
			end
			S_T2: begin
				cmd.op  = bmg_pkg::DP_T2;
				state_d = S_T3;
			end
			S_T3: begin
				cmd.op = bmg_pkg::DP_T3;
				if (cnt_q == 5'(bmg_pkg::TAYLOR_TERMS - 1)) begin
					state_d = status.use_cos ? S_MAG : S_S1;
				end else begin
					cnt_d   = cnt_q + 5'd1;
					state_d = S_T1;
				end
			end
			S_S1: begin
				cmd.op  = bmg_pkg::DP_S1;
				state_d = S_S2;
			end
			S_S2: begin
				cmd.op  = bmg_pkg::DP_S2;
				state_d = S_MAG;
			end
			S_MAG: begin
				cmd.op  = bmg_pkg::DP_MAG;
				state_d = S_RND;
			end
			S_RND: begin
				cmd.op  = bmg_pkg::DP_RND;
				state_d = S_HREAD;
			end
			S_HREAD: begin
				cmd.hop = bmg_pkg::H_READ;
				state_d = (status.command == bmg_pkg::CMD_GEN) ? S_HINC : S_DONE;
			end
			S_HINC: begin
				if (status.hit_ok) cmd.hop = bmg_pkg::H_INC;
				state_d = S_DONE;
			end
			S_CLEAR: begin
				cmd.hop = bmg_pkg::H_CLEAR;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (load_out) begin
					cmd.op  = bmg_pkg::DP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (rsp_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_LOAD))
		else $error("accepted transaction did not start the sequence");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && ovalid_q && !rsp_ready) |=> (state_q == S_DONE))
		else $error("result overwrote one still waiting");

	a_inc_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.hop == bmg_pkg::H_INC) |-> ($past(cmd.hop) == bmg_pkg::H_READ))
		else $error("counter increment without a preceding read");

endmodule

`default_nettype wire

/* src/box_muller_gaussian_noise_histogram_unit.sv */
// Box-Muller Gaussian noise generator with a saturating histogram of its samples.
//
// Requests arrive on a valid/ready channel carrying command, two uniform samples and a bin
// select; each request yields exactly one response transaction on the response channel.
// A generate request runs through the log2 loop of thirty squarings on the single shared
// 32x32 multiplier, the 32-step bit-serial root and the Taylor form, plus the S1 and S2 states
// when the sine form is needed. A read or clear request passes only through a histogram read
// or clear state, and an unused command goes straight to the done state.
// One request is processed at a time; the next is accepted as soon as the finished result
// has moved to the output register, even while that result still waits for the receiver.
// If the receiver stalls with a result pending, the next finished result waits in the
// sequencer until the output register frees, and no further request is accepted meanwhile.
// Reset clears the sequencer, the output valid and all counter valid bits, so every
// histogram bin reads as zero at once; a clear command clears all counter valid bits as well.
// Depends on bmg_pkg, bmg_if, bmg_hist, bmg_datapath and bmg_ctrl.
`default_nettype none

module box_muller_gaussian_noise_histogram_unit #(
	parameter int NUM_BINS    = 10,
	parameter int COUNT_WIDTH = 32,
	parameter int FRAC_BITS   = 12
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bmg_req_if.sink    request,
	bmg_rsp_if.source  response
);
	localparam int AW = $clog2(NUM_BINS);

	bmg_pkg::cmd_t          cmd;
	bmg_pkg::status_t       status;
	logic [AW-1:0]          hist_addr;
	logic [COUNT_WIDTH-1:0] count;

	bmg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.rsp_valid (response.valid),
		.rsp_ready (response.ready),
		.status    (status),
		.cmd       (cmd)
	);

	bmg_datapath #(
		.NUM_BINS    (NUM_BINS),
		.COUNT_WIDTH (COUNT_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.cmd       (cmd),
		.req       (request.data),
		.count     (count),
		.status    (status),
		.hist_addr (hist_addr),
		.rsp       (response.data)
	);

	bmg_hist #(
		.NUM_BINS    (NUM_BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.hop    (cmd.hop),
		.addr   (hist_addr),
		.count  (count)
	);

endmodule

`default_nettype wire

/* sim/box_muller_gaussian_noise_histogram_unit_tb.sv */
// Testbench for the Box-Muller noise and histogram unit: drives request transactions,
// predicts each response with an independent fixed-point model and checks it field by field.
// Depends on bmg_pkg, bmg_if and the unit's RTL.
`timescale 1ns / 1ps

module box_muller_gaussian_noise_histogram_unit_tb;

	localparam int NBINS = 10;
	localparam logic [1:0] CMD_NONE = 2'd3;

	logic clk;
	logic arst_n;
	bit   failed;
	bit   stim_done;

	bmg_req_if request ();
	bmg_rsp_if response ();

	box_muller_gaussian_noise_histogram_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.response (response)
	);

	bmg_pkg::req_t pending_reqs[$];
	bmg_pkg::rsp_t awaited_rsps[$];
	logic [31:0]   hist_model[NBINS];
	int            drv_gap;
	int            mon_gap;

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 150);
	endfunction

	function automatic logic [63:0] neg_log2(input logic [15:0] u);
		int p;
		logic [63:0] m;
		logic [63:0] fr;
		p = 0;
		fr = 0;
		for (int b = 15; b >= 0; b--)
			if (u[b] && p == 0 && b > 0) begin
				p = b;
				break;
			end
		m = 64'(u) << (30 - p);
		for (int i = 0; i < 30; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				fr[29 - i] = 1'b1;
			end
		end
		return (64'(16 - p) << 30) - fr;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Nested Taylor form for cosine (odd = 0) or sine (odd = 1) of x in Q30.
	function automatic logic [63:0] taylor(input logic [63:0] x, input bit odd);
		logic [63:0] y;
		logic [63:0] h;
		int divs_c[5] = '{90, 56, 30, 12, 2};
		int divs_s[5] = '{110, 72, 42, 20, 6};
		y = (x * x) >> 30;
		h = 64'd1 << 30;
		for (int j = 0; j < 5; j++)
			h = (64'd1 << 30) - ((y * h) >> 30) / (odd ? divs_s[j] : divs_c[j]);
		return odd ? (x * h) >> 30 : h;
	endfunction

	function automatic logic signed [15:0] noise_of(input logic [15:0] ua, input logic [15:0] ub);
		logic [63:0] rad;
		logic [63:0] rr;
		logic [63:0] x;
		logic [63:0] cm;
		logic [63:0] sm;
		logic [63:0] rounded;
		logic [13:0] r;
		bit neg;
		if (ua == 0)
			ua = 16'd1;
		rad = (neg_log2(ua) * 64'(bmg_pkg::TWO_LN2_Q28)) >> 30;
		rr = int_sqrt(rad << 28);
		r = ub[13:0];
		if (r <= 14'd8192) begin
			x = (64'(r) * 64'(bmg_pkg::PI_Q30)) >> 15;
			cm = taylor(x, 0);
			sm = taylor(x, 1);
		end else begin
			x = (64'(15'd16384 - r) * 64'(bmg_pkg::PI_Q30)) >> 15;
			cm = taylor(x, 1);
			sm = taylor(x, 0);
		end
		neg = ub[15] ^ ub[14];
		if (ub[14])
			cm = sm;
		rounded = (rr * cm + (64'd1 << 45)) >> 46;
		if (neg) begin
			if (rounded > 32768)
				rounded = 32768;
			return 16'(-rounded);
		end
		if (rounded > 32767)
			rounded = 32767;
		return 16'(rounded);
	endfunction

	function automatic bmg_pkg::rsp_t histogram_step(input bmg_pkg::req_t rq);
		bmg_pkg::rsp_t rs;
		int s;
		rs = '0;
		rs.bin_hit = 4'(NBINS);
		case (rq.command)
			bmg_pkg::CMD_GEN: begin
				rs.noise_sample = noise_of(rq.uniform_a, rq.uniform_b);
				s = rs.noise_sample;
				for (int k = 0; k < NBINS; k++) begin
					if (s > (k - NBINS / 2) * 4096 && s <= (k - NBINS / 2 + 1) * 4096) begin
						if (hist_model[k] != 32'hFFFF_FFFF)
							hist_model[k]++;
						rs.bin_hit = 4'(k);
						break;
					end
				end
			end
			bmg_pkg::CMD_READ: if (rq.bin_select < NBINS)
				rs.bin_count = hist_model[rq.bin_select];
			bmg_pkg::CMD_CLEAR: foreach (hist_model[k])
				hist_model[k] = '0;
			default: ;
		endcase
		return rs;
	endfunction

	function automatic bmg_pkg::req_t make_req(input logic [1:0] c, input logic [15:0] a,
			input logic [15:0] b, input logic [3:0] s);
		bmg_pkg::req_t rq;
		rq.command = c;
		rq.uniform_a = a;
		rq.uniform_b = b;
		rq.bin_select = s;
		return rq;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Driver: one transaction at a time, gaps inserted between items.
	initial begin
		request.valid = 1'b0;
		request.data = '0;
		drv_gap = 0;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (request.valid && request.ready) begin
				request.valid <= 1'b0;
				drv_gap = rand_gap();
			end else if (request.valid) begin
			end else if (drv_gap > 0) begin
				drv_gap--;
			end else if (pending_reqs.size() > 0) begin
				request.data <= pending_reqs.pop_front();
				request.valid <= 1'b1;
			end
		end
	end

	// Prediction happens at acceptance, so counter state follows request order.
	always @(posedge clk) begin
		if (arst_n && request.valid && request.ready)
			awaited_rsps.push_back(histogram_step(request.data));
	end

	initial begin
		response.ready = 1'b0;
		mon_gap = 0;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (mon_gap > 0) begin
				mon_gap--;
				response.ready <= 1'b0;
			end else begin
				response.ready <= 1'b1;
				if ($urandom_range(0, 9) == 0)
					mon_gap = rand_gap();
			end
		end
	end

	always @(posedge clk) begin
		bmg_pkg::rsp_t want;
		if (arst_n && response.valid && response.ready) begin
			if (awaited_rsps.size() == 0) begin
				$error("unexpected response %h", response.data);
				failed = 1'b1;
			end else begin
				want = awaited_rsps.pop_front();
				if (response.data.noise_sample !== want.noise_sample) begin
					$error("noise_sample expected %0d actual %0d",
						want.noise_sample, response.data.noise_sample);
					failed = 1'b1;
				end
				if (response.data.bin_hit !== want.bin_hit) begin
					$error("bin_hit expected %0d actual %0d", want.bin_hit,
						response.data.bin_hit);
					failed = 1'b1;
				end
				if (response.data.bin_count !== want.bin_count) begin
					$error("bin_count expected %0d actual %0d", want.bin_count,
						response.data.bin_count);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		logic [1:0] c;
		logic [15:0] a;
		int r;
		failed = 1'b0;
		stim_done = 1'b0;
		foreach (hist_model[k])
			hist_model[k] = '0;
		// Directed: zero/extreme uniforms, all quadrants, octant swap, reads, clear.
		pending_reqs.push_back(make_req(bmg_pkg::CMD_GEN, 16'h0000, 16'h0000, 4'd0));
		pending_reqs.push_back(make_req(bmg_pkg::CMD_GEN, 16'h0000, 16'h8000, 4'd15));
		pending_reqs.push_back(make_req(bmg_pkg::CMD_GEN, 16'hFFFF, 16'hFFFF, 4'd0));
		pending_reqs.push_back(make_req(bmg_pkg::CMD_GEN, 16'h0001, 16'h4000, 4'd0));
		pending_reqs.push_back(make_req(bmg_pkg::CMD_GEN, 16'h0001, 16'hC000, 4'd0));
		pending_reqs.push_back(make_req(bmg_pkg::CMD_GEN, 16'h8000, 16'h2000, 4'd0));
		pending_reqs.push_back(make_req(bmg_pkg::CMD_GEN, 16'h1234, 16'h2001, 4'd0));
		pending_reqs.push_back(make_req(bmg_pkg::CMD_GEN, 16'h0400, 16'h6ABC, 4'd0));
		pending_reqs.push_back(make_req(bmg_pkg::CMD_GEN, 16'h7FFF, 16'hA5A5, 4'd0));
		pending_reqs.push_back(make_req(bmg_pkg::CMD_GEN, 16'h0003, 16'h3FFF, 4'd0));
		for (int k = 0; k < 16; k++)
			pending_reqs.push_back(make_req(bmg_pkg::CMD_READ, 16'hFFFF, 16'hFFFF, 4'(k)));
		pending_reqs.push_back(make_req(CMD_NONE, 16'hFFFF, 16'hFFFF, 4'd15));
		pending_reqs.push_back(make_req(bmg_pkg::CMD_CLEAR, 16'hFFFF, 16'h0000, 4'd3));
		pending_reqs.push_back(make_req(bmg_pkg::CMD_READ, 16'h0000, 16'h0000, 4'd0));
		for (int n = 0; n < 800; n++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				c = bmg_pkg::CMD_GEN;
			else if (r < 92)
				c = bmg_pkg::CMD_READ;
			else if (r < 96)
				c = bmg_pkg::CMD_CLEAR;
			else
				c = CMD_NONE;
			a = 16'($urandom);
			// Small uniforms reach the tails.
			if ($urandom_range(0, 7) == 0)
				a = 16'($urandom_range(0, 40));
			pending_reqs.push_back(make_req(c, a, 16'($urandom), 4'($urandom)));
		end
		wait (pending_reqs.size() == 0 && !request.valid);
		wait (awaited_rsps.size() == 0);
		repeat (200) @(posedge clk);
		if (!failed && awaited_rsps.size() == 0)
			$display("box_muller_gaussian_noise_histogram_unit verification clean");
		else
			$display("box_muller_gaussian_noise_histogram_unit verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("box_muller_gaussian_noise_histogram_unit verification failed");
		$finish;
	end

endmodule
